// ===== src/alm_pkg.sv =====
// ----------------------------------------------------------------------------
// alm_pkg: shared types and constants for the anchored literal matcher
// Transaction payloads, match mode codes and configuration register indexes.
// ----------------------------------------------------------------------------
package alm_pkg;

  localparam int OFF_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PAT_WORDS = 4;
  localparam int PAT_WORD_W = 64;

  typedef enum logic [2:0] {
    MODE_EMPTY     = 3'd0,
    MODE_NOT_EMPTY = 3'd1,
    MODE_EXACT     = 3'd2,
    MODE_PREFIX    = 3'd3,
    MODE_SUFFIX    = 3'd4,
    MODE_SUBSTRING = 3'd5
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATCH_MODE     = 3'd0,
    REG_IGNORE_CASE    = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_PATTERN_WORD_0 = 3'd3,
    REG_PATTERN_WORD_1 = 3'd4,
    REG_PATTERN_WORD_2 = 3'd5,
    REG_PATTERN_WORD_3 = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] subject_byte;
    logic       last_byte;
    logic       empty_subject;
  } in_item_t;

  typedef struct packed {
    logic             matched;
    logic [OFF_W-1:0] match_start;
    logic [OFF_W-1:0] match_end;
    logic             length_overflow;
  } out_item_t;

endpackage

// ===== src/alm_stream_if.sv =====
// ----------------------------------------------------------------------------
// alm_stream_if: valid/ready stream channel
// Carries one payload per transaction; accepted when valid and ready are high.
// ----------------------------------------------------------------------------
interface alm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/anchored_literal_matcher.sv =====
// ----------------------------------------------------------------------------
// anchored_literal_matcher: streaming literal pattern match over subject bytes
// Compares a window of recent subject bytes with a configured pattern.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one subject byte per transaction with a last-byte mark,
//   or an empty-subject mark that stands for a whole zero-length subject.
//   out_chan carries one result per subject: matched, start/end offsets and
//   the length overflow flag.
//   cfg_we/cfg_index/cfg_wdata write the mode, case folding, pattern length
//   and the four pattern words; write only while no result is pending.
// Throughput and result timing:
//   One input transaction per cycle while out_chan is not stalled. The window
//   compare, state update and end-of-subject decision are combinational; the
//   result appears in the output register in the cycle after the final byte is accepted.
// Reset:
//   Synchronous, active low. Clears configuration, subject state and the
//   output valid; the block takes input from the first cycle after reset.
// Stall:
//   While out_chan is stalled with a result held, in_chan stays ready only
//   if the held result is taken in the same cycle.
// ----------------------------------------------------------------------------
module anchored_literal_matcher #(
  parameter int PATTERN_BYTES   = 32,
  parameter int MAX_SUBJECT_LEN = 65535
) (
  input  logic                            clk,
  input  logic                            rst_n,
  alm_stream_if.sink                      in_chan,
  alm_stream_if.source                    out_chan,
  input  logic                            cfg_we,
  input  logic [alm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [alm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int LEN_W = $clog2(PATTERN_BYTES + 1);
  localparam int IDX_W = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
  localparam int CNT_W = $clog2(MAX_SUBJECT_LEN + 1);

  // configuration
  logic [2:0]                     mode_r;
  logic                           icase_r;
  logic [5:0]                     plen_r;
  logic [alm_pkg::PAT_WORD_W-1:0] pat_w_r [alm_pkg::PAT_WORDS];

  // subject state
  logic [7:0]                 win_r [PATTERN_BYTES];
  logic [CNT_W-1:0]           cnt_r;
  logic                       found_r;
  logic [alm_pkg::OFF_W-1:0]  start_r;
  logic                       prefix_r;
  logic                       ovf_r;

  // result register
  logic                 out_valid_r;
  alm_pkg::out_item_t   out_data_r;

  // combinational
  logic [7:0]                 pat_b  [PATTERN_BYTES];
  logic [7:0]                 win_sh [PATTERN_BYTES];
  logic [7:0]                 byte_lc;
  logic [LEN_W-1:0]           eff_len;
  logic [LEN_W-1:0]           pidx;
  logic [CNT_W-1:0]           len_ext;
  logic                       in_ready;
  logic                       acc;
  logic                       fin;
  logic                       drop;
  logic                       cmp_ok;
  logic                       hit;
  logic                       upd;
  logic [CNT_W-1:0]           cnt_f;
  logic                       ovf_f;
  logic                       prefix_f;
  logic                       found_f;
  logic [alm_pkg::OFF_W-1:0]  start_f;
  logic [CNT_W-1:0]           diff;
  logic [31:0]                diff32;
  logic [31:0]                cnt32;
  logic [31:0]                len32;
  logic [alm_pkg::OFF_W-1:0]  n16;
  logic [alm_pkg::OFF_W-1:0]  l16;
  alm_pkg::out_item_t         res_nxt;

  assign in_ready       = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = in_ready;
  assign acc            = in_chan.valid && in_ready;
  assign fin            = in_chan.data.last_byte || in_chan.data.empty_subject;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  always_comb begin
    for (int j = 0; j < PATTERN_BYTES; j++) begin
      if (j < 32) begin
        pat_b[j] = pat_w_r[(j >> 3) & 3][8 * (j & 7) +: 8];
      end else begin
        pat_b[j] = 8'h00;
      end
    end
  end

  always_comb begin
    byte_lc = in_chan.data.subject_byte;
    if (icase_r && byte_lc >= 8'h41 && byte_lc <= 8'h5A) begin
      byte_lc = byte_lc | 8'h20;
    end
    if (32'(plen_r) > PATTERN_BYTES) begin
      eff_len = LEN_W'(PATTERN_BYTES);
    end else begin
      eff_len = LEN_W'(plen_r);
    end
    len_ext = CNT_W'(eff_len);
  end

  // newest byte at index 0; pattern's last byte aligns with the newest byte
  always_comb begin
    cmp_ok = 1'b1;
    pidx   = '0;
    for (int j = 0; j < PATTERN_BYTES; j++) begin
      win_sh[j] = (j == 0) ? byte_lc : win_r[(j == 0) ? 0 : j - 1];
      pidx = eff_len - LEN_W'(j) - LEN_W'(1);
      if (j < 32'(eff_len)) begin
        cmp_ok = cmp_ok && (win_sh[j] == pat_b[pidx[IDX_W-1:0]]);
      end
    end
  end

  always_comb begin
    drop = !in_chan.data.empty_subject && (cnt_r >= CNT_W'(MAX_SUBJECT_LEN));
    if (in_chan.data.empty_subject) begin
      cnt_f = '0;
    end else if (drop) begin
      cnt_f = cnt_r;
    end else begin
      cnt_f = cnt_r + CNT_W'(1);
    end
    ovf_f = !in_chan.data.empty_subject && (ovf_r || drop);
    hit   = (cnt_f >= len_ext) && cmp_ok;
    upd   = !in_chan.data.empty_subject && !drop && (eff_len != '0) && hit;
    diff   = cnt_f - len_ext;
    diff32 = 32'(diff);
    cnt32  = 32'(cnt_f);
    len32  = 32'(eff_len);
    n16    = cnt32[alm_pkg::OFF_W-1:0];
    l16    = len32[alm_pkg::OFF_W-1:0];
    if (in_chan.data.empty_subject) begin
      prefix_f = 1'b0;
      found_f  = 1'b0;
      start_f  = '0;
    end else begin
      prefix_f = prefix_r || (upd && cnt_f == len_ext);
      found_f  = found_r || upd;
      start_f  = (upd && !found_r) ? diff32[alm_pkg::OFF_W-1:0] : start_r;
    end
  end

  always_comb begin
    res_nxt = '0;
    unique case (mode_r)
      alm_pkg::MODE_EMPTY: begin
        res_nxt.matched = (cnt_f == '0);
      end
      alm_pkg::MODE_NOT_EMPTY: begin
        res_nxt.matched   = (cnt_f != '0);
        res_nxt.match_end = n16;
      end
      alm_pkg::MODE_EXACT: begin
        res_nxt.matched   = (cnt_f == len_ext) && ((eff_len == '0) || prefix_f);
        res_nxt.match_end = n16;
      end
      alm_pkg::MODE_PREFIX: begin
        res_nxt.matched   = (eff_len == '0) || prefix_f;
        res_nxt.match_end = l16;
      end
      alm_pkg::MODE_SUFFIX: begin
        res_nxt.matched     = hit;
        res_nxt.match_start = n16 - l16;
        res_nxt.match_end   = n16;
      end
      alm_pkg::MODE_SUBSTRING: begin
        if (eff_len == '0) begin
          res_nxt.matched = 1'b1;
        end else if (found_f) begin
          res_nxt.matched     = 1'b1;
          res_nxt.match_start = start_f;
          res_nxt.match_end   = start_f + l16;
        end
      end
      default: res_nxt.matched = 1'b0;
    endcase
    if (ovf_f || !res_nxt.matched) begin
      res_nxt.matched     = 1'b0;
      res_nxt.match_start = '0;
      res_nxt.match_end   = '0;
    end
    res_nxt.length_overflow = ovf_f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      icase_r  <= 1'b0;
      plen_r   <= '0;
      for (int k = 0; k < alm_pkg::PAT_WORDS; k++) begin
        pat_w_r[k] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        alm_pkg::REG_MATCH_MODE:     mode_r     <= cfg_wdata[2:0];
        alm_pkg::REG_IGNORE_CASE:    icase_r    <= cfg_wdata[0];
        alm_pkg::REG_PATTERN_LENGTH: plen_r     <= cfg_wdata[5:0];
        alm_pkg::REG_PATTERN_WORD_0: pat_w_r[0] <= cfg_wdata;
        alm_pkg::REG_PATTERN_WORD_1: pat_w_r[1] <= cfg_wdata;
        alm_pkg::REG_PATTERN_WORD_2: pat_w_r[2] <= cfg_wdata;
        alm_pkg::REG_PATTERN_WORD_3: pat_w_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !in_chan.data.empty_subject && !drop) begin
      for (int j = 0; j < PATTERN_BYTES; j++) begin
        win_r[j] <= win_sh[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      found_r     <= 1'b0;
      start_r     <= '0;
      prefix_r    <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        if (fin) begin
          cnt_r    <= '0;
          found_r  <= 1'b0;
          start_r  <= '0;
          prefix_r <= 1'b0;
          ovf_r    <= 1'b0;
        end else begin
          cnt_r    <= cnt_f;
          found_r  <= found_f;
          start_r  <= start_f;
          prefix_r <= prefix_f;
          ovf_r    <= ovf_f;
        end
      end
      if (acc && fin) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && fin) begin
      out_data_r <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SUBJECT_LEN))
    else $error("byte count beyond maximum subject length");

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && fin) |=> (cnt_r == '0 && !ovf_r && !found_r && !prefix_r))
    else $error("subject state not cleared after result");

  a_no_match_on_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.matched && out_data_r.length_overflow))
    else $error("match reported on overflowed subject");

  a_prefix_implies_found: assert property (@(posedge clk) disable iff (!rst_n)
    prefix_r |-> found_r)
    else $error("prefix hit without recorded occurrence");
`endif

endmodule

// ===== verif/tb_anchored_literal_matcher.sv =====
// ----------------------------------------------------------------------------
// tb_anchored_literal_matcher: self-checking testbench for the literal matcher
// Streams subjects through the input channel under bursty traffic and a
// stalling receiver, predicts each end-of-subject verdict in a behavioral
// copy of the matcher, and compares every result field by field. Covers all
// match modes, case folding, zero and saturated pattern lengths, empty and
// aborted subjects and register changes inside a subject.
// ----------------------------------------------------------------------------
module tb_anchored_literal_matcher;

  localparam int PAT_BYTES   = 32;
  localparam int MAX_SUBJECT = 65535;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [alm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [alm_pkg::CFG_DATA_W-1:0] cfg_wdata;

  alm_stream_if #(.T(alm_pkg::in_item_t))  in_chan ();
  alm_stream_if #(.T(alm_pkg::out_item_t)) out_chan ();

  anchored_literal_matcher #(
    .PATTERN_BYTES  (PAT_BYTES),
    .MAX_SUBJECT_LEN(MAX_SUBJECT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // matcher model: registers as written, subject state as streamed
  logic [2:0]   cur_mode;
  logic         cur_icase;
  logic [5:0]   cur_plen;
  logic [255:0] cur_pattern;
  logic [7:0]   recent_win [PAT_BYTES];
  int           sub_len;
  logic         sub_found;
  int           found_at;
  logic         pre_hit;
  logic         sub_ovf;

  alm_pkg::out_item_t verdict_q [$];
  alm_pkg::out_item_t want;
  alm_pkg::out_item_t got;

  int items_sent;
  int verdicts_seen;
  int mismatches;
  int settings_used;
  int burst_left;

  int          sink_tick = 0;
  int          sink_style = 0;
  logic [31:0] sink_bits = '1;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #(12 * 2_000_000);
    $display("TEST FAILED");
    $finish;
  end

  function automatic int eff_len();
    return (cur_plen > PAT_BYTES) ? PAT_BYTES : int'(cur_plen);
  endfunction

  function automatic logic window_matches(int len);
    if (sub_len < len) return 1'b0;
    for (int i = 0; i < len; i++) begin
      if (recent_win[len - 1 - i] != cur_pattern[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_subject_model();
    for (int i = 0; i < PAT_BYTES; i++) recent_win[i] = '0;
    sub_len   = 0;
    sub_found = 1'b0;
    found_at  = 0;
    pre_hit   = 1'b0;
    sub_ovf   = 1'b0;
  endfunction

  function automatic void close_subject_model();
    alm_pkg::out_item_t r;
    int len;
    int n;
    int s;
    int e;
    logic m;
    len = eff_len();
    n = sub_len;
    m = 1'b0;
    s = 0;
    e = 0;
    if (!sub_ovf) begin
      case (cur_mode)
        alm_pkg::MODE_EMPTY: m = (n == 0);
        alm_pkg::MODE_NOT_EMPTY: begin
          m = (n > 0);
          e = n;
        end
        alm_pkg::MODE_EXACT: begin
          m = (n == len) && (len == 0 || pre_hit);
          e = n;
        end
        alm_pkg::MODE_PREFIX: begin
          m = (len == 0) || pre_hit;
          e = len;
        end
        alm_pkg::MODE_SUFFIX: begin
          m = window_matches(len);
          s = n - len;
          e = n;
        end
        alm_pkg::MODE_SUBSTRING: begin
          if (len == 0) begin
            m = 1'b1;
          end else if (sub_found) begin
            m = 1'b1;
            s = found_at;
            e = found_at + len;
          end
        end
        default: m = 1'b0;
      endcase
    end
    if (!m) begin
      s = 0;
      e = 0;
    end
    r.matched         = m;
    r.match_start     = s[alm_pkg::OFF_W-1:0];
    r.match_end       = e[alm_pkg::OFF_W-1:0];
    r.length_overflow = sub_ovf;
    verdict_q.push_back(r);
    clear_subject_model();
  endfunction

  function automatic void predict_verdict(alm_pkg::in_item_t it);
    logic [7:0] b;
    int len;
    if (it.empty_subject) begin
      clear_subject_model();
      close_subject_model();
      return;
    end
    b = it.subject_byte;
    if (cur_icase && b >= "A" && b <= "Z") b = b + 8'd32;
    if (sub_len >= MAX_SUBJECT) begin
      sub_ovf = 1'b1;
    end else begin
      for (int i = PAT_BYTES - 1; i > 0; i--) recent_win[i] = recent_win[i-1];
      recent_win[0] = b;
      sub_len++;
      len = eff_len();
      if (len > 0 && window_matches(len)) begin
        if (sub_len == len) pre_hit = 1'b1;
        if (!sub_found) begin
          sub_found = 1'b1;
          found_at  = sub_len - len;
        end
      end
    end
    if (it.last_byte) close_subject_model();
  endfunction

  // receiver: ready follows a randomly chosen pattern that is reshuffled when its countdown runs out
  always @(posedge clk) begin
    if (sink_tick == 0) begin
      sink_style = $urandom_range(0, 3);
      sink_bits  = $urandom;
      sink_tick  = $urandom_range(16, 48);
    end else begin
      sink_tick = sink_tick - 1;
    end
    case (sink_style)
      0: out_chan.ready <= 1'b1;
      1: out_chan.ready <= sink_bits[sink_tick % 32];
      2: out_chan.ready <= (sink_tick % 8) < 2;
      default: out_chan.ready <= sink_bits[sink_tick % 32] | sink_bits[(sink_tick + 7) % 32];
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = out_chan.data;
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        $error("unexpected result transaction: matched %0d start %0d end %0d overflow %0d",
               got.matched, got.match_start, got.match_end, got.length_overflow);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (got.matched !== want.matched) begin
          $error("matched: expected %0d, got %0d", want.matched, got.matched);
          mismatches++;
        end
        if (got.match_start !== want.match_start) begin
          $error("match_start: expected %0d, got %0d", want.match_start, got.match_start);
          mismatches++;
        end
        if (got.match_end !== want.match_end) begin
          $error("match_end: expected %0d, got %0d", want.match_end, got.match_end);
          mismatches++;
        end
        if (got.length_overflow !== want.length_overflow) begin
          $error("length_overflow: expected %0d, got %0d",
                 want.length_overflow, got.length_overflow);
          mismatches++;
        end
      end
    end
  end

  task automatic send_item(logic [7:0] b, logic last, logic empty);
    alm_pkg::in_item_t it;
    int gap;
    it.subject_byte  = b;
    it.last_byte     = last;
    it.empty_subject = empty;
    in_chan.valid <= 1'b1;
    in_chan.data  <= it;
    do @(posedge clk); while (!in_chan.ready);
    predict_verdict(it);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_subject(logic [7:0] bytes [$]);
    if (bytes.size() == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end else begin
      for (int i = 0; i < bytes.size(); i++) send_item(bytes[i], i == bytes.size() - 1, 1'b0);
    end
  endtask

  task automatic send_text(string s);
    if (s.len() == 0) begin
      send_item(8'hFF, 1'b1, 1'b1);
    end else begin
      for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1, 1'b0);
    end
  endtask

  function automatic logic [255:0] pattern_of(string s);
    logic [255:0] p;
    p = '0;
    for (int i = 0; i < s.len(); i++) p[8*i +: 8] = s[i];
    return p;
  endfunction

  // drain all pending results, then let the pipeline go quiet
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(alm_pkg::cfg_reg_t r, logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    case (r)
      alm_pkg::REG_MATCH_MODE:     cur_mode = v[2:0];
      alm_pkg::REG_IGNORE_CASE:    cur_icase = v[0];
      alm_pkg::REG_PATTERN_LENGTH: cur_plen = v[5:0];
      alm_pkg::REG_PATTERN_WORD_0: cur_pattern[63:0] = v;
      alm_pkg::REG_PATTERN_WORD_1: cur_pattern[127:64] = v;
      alm_pkg::REG_PATTERN_WORD_2: cur_pattern[191:128] = v;
      alm_pkg::REG_PATTERN_WORD_3: cur_pattern[255:192] = v;
      default: ;
    endcase
  endtask

  // unused upper bits of the narrow registers sometimes carry garbage
  function automatic logic [63:0] with_junk(logic [63:0] v, int w);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) return (junk << w) | v;
    return v;
  endfunction

  task automatic program_matcher(logic [2:0] mode, logic icase, logic [5:0] plen,
                                 logic [255:0] pat);
    write_reg(alm_pkg::REG_MATCH_MODE, with_junk(64'(mode), 3));
    write_reg(alm_pkg::REG_IGNORE_CASE, with_junk(64'(icase), 1));
    write_reg(alm_pkg::REG_PATTERN_LENGTH, with_junk(64'(plen), 6));
    write_reg(alm_pkg::REG_PATTERN_WORD_0, pat[63:0]);
    write_reg(alm_pkg::REG_PATTERN_WORD_1, pat[127:64]);
    write_reg(alm_pkg::REG_PATTERN_WORD_2, pat[191:128]);
    write_reg(alm_pkg::REG_PATTERN_WORD_3, pat[255:192]);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic test_empty_modes();
    program_matcher(alm_pkg::MODE_EMPTY, 1'b0, 6'd0, '0);
    send_text("");
    send_text("q");
    send_item("z", 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    settle();
    program_matcher(alm_pkg::MODE_NOT_EMPTY, 1'b0, 6'd0, '0);
    send_text("");
    send_text("xy");
    settle();
  endtask

  task automatic test_exact_mode();
    program_matcher(alm_pkg::MODE_EXACT, 1'b0, 6'd2, {240'd0, 8'hFF, 8'h00});
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_text("a");
    settle();
    program_matcher(alm_pkg::MODE_EXACT, 1'b0, 6'd0, pattern_of("ab"));
    send_text("");
    send_text("a");
    settle();
  endtask

  task automatic test_anchored_modes();
    program_matcher(alm_pkg::MODE_PREFIX, 1'b0, 6'd2, pattern_of("ab"));
    send_text("abx");
    send_text("xab");
    settle();
    program_matcher(alm_pkg::MODE_SUFFIX, 1'b0, 6'd2, pattern_of("ab"));
    send_text("xab");
    settle();
    program_matcher(alm_pkg::MODE_SUBSTRING, 1'b0, 6'd2, pattern_of("ab"));
    send_text("xabab");
    settle();
    // zero-length pattern
    program_matcher(alm_pkg::MODE_PREFIX, 1'b0, 6'd0, pattern_of("k"));
    send_text("k");
    settle();
    program_matcher(alm_pkg::MODE_SUFFIX, 1'b0, 6'd0, pattern_of("k"));
    send_text("kk");
    settle();
    program_matcher(alm_pkg::MODE_SUBSTRING, 1'b0, 6'd0, pattern_of("k"));
    send_text("k");
    settle();
  endtask

  task automatic test_case_folding();
    // neighbors of the letter range must pass through unchanged
    program_matcher(alm_pkg::MODE_SUBSTRING, 1'b1, 6'd3, pattern_of("@[z"));
    send_text("@[Z");
    send_text("`{z");
    settle();
    program_matcher(alm_pkg::MODE_SUBSTRING, 1'b0, 6'd3, pattern_of("@[z"));
    send_text("@[Z");
    settle();
  endtask

  task automatic test_unused_modes();
    program_matcher(3'd6, 1'b0, 6'd0, '0);
    send_text("a");
    settle();
    program_matcher(3'd7, 1'b0, 6'd0, '0);
    send_text("");
    settle();
  endtask

  task automatic test_register_change_mid_subject();
    program_matcher(alm_pkg::MODE_PREFIX, 1'b0, 6'd2, pattern_of("ab"));
    send_item("a", 1'b0, 1'b0);
    send_item("b", 1'b0, 1'b0);
    settle();
    program_matcher(alm_pkg::MODE_SUBSTRING, 1'b0, 6'd3, pattern_of("bcd"));
    send_item("c", 1'b0, 1'b0);
    settle();
    program_matcher(alm_pkg::MODE_EXACT, 1'b1, 6'd2, pattern_of("ab"));
    send_item("d", 1'b1, 1'b0);
    settle();
  endtask

  function automatic logic [7:0] filler_byte(logic [255:0] pat, logic icase);
    logic [7:0] b;
    int idx;
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    idx = $urandom_range(0, PAT_BYTES - 1);
    b = pat[8*idx +: 8];
    if (icase && b >= "a" && b <= "z" && $urandom_range(0, 1)) b = b - 8'd32;
    return b;
  endfunction

  task automatic test_random_traffic();
    logic [2:0]   mode;
    logic         icase;
    logic [5:0]   plen;
    logic [255:0] pat;
    logic         small_alpha;
    logic [7:0]   b;
    logic [7:0]   subj [$];
    int len;
    int r;
    int start;
    for (int ph = 0; ph < 14; ph++) begin
      small_alpha = $urandom_range(0, 3) != 0;
      for (int k = 0; k < PAT_BYTES; k++) begin
        pat[8*k +: 8] = small_alpha ? 8'h61 + 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 255));
      end
      icase = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 15);
      if (r < 12) mode = 3'(r % 6);
      else if (r < 14) mode = alm_pkg::MODE_SUBSTRING;
      else mode = 3'd6 + 3'(r % 2);
      r = $urandom_range(0, 15);
      if (r == 0) plen = 6'd0;
      else if (r == 1) plen = 6'd32;
      else if (r == 2) plen = 6'($urandom_range(33, 63));
      else plen = 6'($urandom_range(1, 6));
      case (ph)
        0: begin
          mode = alm_pkg::MODE_EXACT;
          icase = 1'b1;
          plen = 6'd63;
          pat = '1;
        end
        1: begin
          mode = alm_pkg::MODE_PREFIX;
          icase = 1'b0;
          plen = 6'd32;
          pat = '0;
        end
        2: begin
          mode = alm_pkg::MODE_SUFFIX;
          plen = 6'd1;
        end
        3: begin
          mode = alm_pkg::MODE_SUBSTRING;
          plen = 6'd32;
        end
        default: ;
      endcase
      program_matcher(mode, icase, plen, pat);
      len = (plen > PAT_BYTES) ? PAT_BYTES : int'(plen);
      start = items_sent;
      while (items_sent - start < 70) begin
        subj.delete();
        r = $urandom_range(0, 19);
        if (r == 0) begin
          send_subject(subj);
        end else if (r == 1) begin
          // aborted subject
          repeat ($urandom_range(1, 4)) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
          send_subject(subj);
        end else if (r == 2) begin
          repeat ($urandom_range(1, 6)) subj.push_back(8'($urandom_range(0, 255)));
          send_subject(subj);
        end else begin
          if ($urandom_range(0, 1)) repeat ($urandom_range(1, 4)) subj.push_back(filler_byte(pat, icase));
          if ($urandom_range(0, 9) < 7) begin
            for (int k = 0; k < len; k++) begin
              b = pat[8*k +: 8];
              if (icase && b >= "a" && b <= "z" && $urandom_range(0, 1)) b = b - 8'd32;
              subj.push_back(b);
            end
          end
          if ($urandom_range(0, 1)) repeat ($urandom_range(1, 4)) subj.push_back(filler_byte(pat, icase));
          send_subject(subj);
        end
      end
      settle();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = alm_pkg::REG_MATCH_MODE;
    cfg_wdata     = '0;
    in_chan.valid = 1'b0;
    in_chan.data  = '0;
    cur_mode      = alm_pkg::MODE_EMPTY;
    cur_icase     = 1'b0;
    cur_plen      = '0;
    cur_pattern   = '0;
    items_sent    = 0;
    verdicts_seen = 0;
    mismatches    = 0;
    settings_used = 0;
    burst_left    = 0;
    clear_subject_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_modes();
    test_exact_mode();
    test_anchored_modes();
    test_case_folding();
    test_unused_modes();
    test_register_change_mid_subject();
    test_random_traffic();
    settle();

    $display("Run covered %0d input transactions and %0d results over %0d register settings,",
             items_sent, verdicts_seen, settings_used);
    $display("all six modes plus unused codes, case folding, empty and aborted subjects.");
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
